// ----- design/flsc_pkg.sv -----
// shared types and constants for the fail-secure lock controller
package flsc_pkg;

  localparam int unsigned TimerBitsDefault = 16;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] OpenPulseReset    = 16'd2000;
  localparam logic [7:0]  DebounceReset     = 8'd30;
  localparam logic [15:0] CommsTimeoutReset = 16'd5000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOpenPulse    = 2'd0,
    CfgDebounce     = 2'd1,
    CfgCommsTimeout = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] open_pulse_ticks;
    logic [7:0]  debounce_ticks;
    logic [15:0] comms_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic button_level;
    logic door_sensor_level;
    logic command_valid;
    logic command_unlock;
  } in_item_t;

  typedef struct packed {
    logic open_drive;
    logic comms_lost;
    logic policy_unlocked;
    logic physically_locked;
  } out_item_t;

endpackage

// ----- design/flsc_cfg_regs.sv -----
// configuration register file of the lock controller
module flsc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [flsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [flsc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output flsc_pkg::cfg_t                cfg_o
);

  flsc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        flsc_pkg::CfgOpenPulse:    cfg_d.open_pulse_ticks    = cfg_wdata_i[15:0];
        flsc_pkg::CfgDebounce:     cfg_d.debounce_ticks      = cfg_wdata_i[7:0];
        flsc_pkg::CfgCommsTimeout: cfg_d.comms_timeout_ticks = cfg_wdata_i[15:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_pulse_ticks    <= flsc_pkg::OpenPulseReset;
      cfg_q.debounce_ticks      <= flsc_pkg::DebounceReset;
      cfg_q.comms_timeout_ticks <= flsc_pkg::CommsTimeoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/flsc_core.sv -----
// lock control state and per-tick step logic
module flsc_core #(
  parameter int unsigned TIMER_BITS = flsc_pkg::TimerBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  flsc_pkg::in_item_t  item_i,
  input  flsc_pkg::cfg_t      cfg_i,
  output flsc_pkg::out_item_t result_o
);

  localparam int unsigned CmpW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic                  policy_q, policy_d;
  logic                  seen_q, seen_d;
  logic [TIMER_BITS-1:0] since_cmd_q, since_cmd_d;
  logic                  last_btn_q, last_btn_d;
  logic [TIMER_BITS-1:0] since_btn_q, since_btn_d;
  logic                  stable_btn_q, stable_btn_d;
  logic                  pulse_q, pulse_d;
  logic [TIMER_BITS-1:0] age_q, age_d;

  logic                  lost;
  logic                  press;
  logic [CmpW-1:0]       since_cmd_x, timeout_x, age_x, open_x;

  always_comb begin
    policy_d     = policy_q;
    seen_d       = seen_q;
    last_btn_d   = last_btn_q;
    stable_btn_d = stable_btn_q;
    pulse_d      = pulse_q;
    press        = 1'b0;

    // saturating tick counters
    since_cmd_d = (&since_cmd_q) ? since_cmd_q : since_cmd_q + 1'b1;
    since_btn_d = (&since_btn_q) ? since_btn_q : since_btn_q + 1'b1;
    age_d       = (pulse_q && !(&age_q)) ? age_q + 1'b1 : age_q;

    if (item_i.command_valid) begin
      policy_d    = item_i.command_unlock;
      seen_d      = 1'b1;
      since_cmd_d = '0;
    end

    since_cmd_x = CmpW'(since_cmd_d);
    timeout_x   = CmpW'(cfg_i.comms_timeout_ticks);
    age_x       = CmpW'(age_d);
    open_x      = CmpW'(cfg_i.open_pulse_ticks);

    lost = !seen_d || (&since_cmd_d) || (since_cmd_x > timeout_x);

    if (pulse_q) begin
      if ((age_x >= open_x) || (&age_d)) begin
        pulse_d = 1'b0;
      end
    end else if (!lost) begin
      if (item_i.button_level != last_btn_q) begin
        since_btn_d = '0;
        last_btn_d  = item_i.button_level;
      end
      if ((since_btn_d > TIMER_BITS'(cfg_i.debounce_ticks)) &&
          (item_i.button_level != stable_btn_q)) begin
        stable_btn_d = item_i.button_level;
        press        = !item_i.button_level;
      end
      if (press && policy_d && !item_i.door_sensor_level) begin
        pulse_d = 1'b1;
        age_d   = '0;
      end
    end

    result_o.open_drive        = pulse_d;
    result_o.comms_lost        = lost;
    result_o.policy_unlocked   = policy_d;
    result_o.physically_locked = !item_i.door_sensor_level;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q     <= 1'b0;
      seen_q       <= 1'b0;
      since_cmd_q  <= '0;
      last_btn_q   <= 1'b1;
      since_btn_q  <= '0;
      stable_btn_q <= 1'b1;
      pulse_q      <= 1'b0;
      age_q        <= '0;
    end else if (fire_i) begin
      policy_q     <= policy_d;
      seen_q       <= seen_d;
      since_cmd_q  <= since_cmd_d;
      last_btn_q   <= last_btn_d;
      since_btn_q  <= since_btn_d;
      stable_btn_q <= stable_btn_d;
      pulse_q      <= pulse_d;
      age_q        <= age_d;
    end
  end

endmodule

// ----- design/fail_secure_lock_controller.sv -----
// fail-secure lock controller top level: request registers and core
//
// One input request is one millisecond tick carrying the raw button level,
// the door sensor level and an optional server command. Each accepted
// request yields exactly one result request: solenoid drive, comms lost,
// commanded policy and physical lock state after that tick.
// Both channels use valid/stall. A request is registered in the input
// register on acceptance, then stepped through the core and written into
// the result register once that register is free or being taken, and
// out_valid_o rises when it is there; one request per cycle is sustained
// while the receiver does not stall. The core state registers update on
// every such step, which sets that rate.
// When the receiver stalls, the result register holds its request and the
// input register still takes one more request; in_stall_o rises only when
// both registers are full.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at the
// next clock edge; indexes past the register list are ignored.
// Reset empties both registers (clears their valid flags), drops the pulse, marks no command seen and
// loads the default pulse, debounce and timeout lengths.
module fail_secure_lock_controller #(
  parameter int unsigned TIMER_BITS = flsc_pkg::TimerBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  flsc_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output flsc_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [flsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [flsc_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic                in_valid_q, in_valid_d;
  flsc_pkg::in_item_t  in_item_q;
  logic                out_valid_q, out_valid_d;
  flsc_pkg::out_item_t out_item_q;
  flsc_pkg::out_item_t result;
  flsc_pkg::cfg_t      cfg;
  logic                advance;
  logic                in_accept;

  assign advance   = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  flsc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  flsc_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_data_i;
    end
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the fail-secure lock controller with a tick-level predictor
module testbench;

  localparam int unsigned TimerBits  = flsc_pkg::TimerBitsDefault;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned MaxPrinted = 100;

  localparam logic [3:0] DirectedTicks [25] = '{
    4'b1100, 4'b0001, 4'b1011, 4'b0000, 4'b0000, 4'b0000, 4'b1110, 4'b1100, 4'b1100,
    4'b1100, 4'b0000, 4'b1000, 4'b1000, 4'b1000, 4'b1011, 4'b0100, 4'b0100, 4'b0100,
    4'b1100, 4'b1100, 4'b1100, 4'b0000, 4'b0000, 4'b0000, 4'b0010
  };

  class lock_scoreboard;
    logic [15:0]          pulse_len;
    logic [7:0]           debounce_len;
    logic [15:0]          timeout_len;
    logic                 policy;
    logic                 cmd_seen;
    logic                 last_btn;
    logic                 stable_btn;
    logic                 pulse_on;
    logic [TimerBits-1:0] since_cmd;
    logic [TimerBits-1:0] since_btn;
    logic [TimerBits-1:0] pulse_age;
    flsc_pkg::out_item_t  expected_q[$];
    int unsigned          n_fail;
    int unsigned          n_checked;

    function new();
      pulse_len    = flsc_pkg::OpenPulseReset;
      debounce_len = flsc_pkg::DebounceReset;
      timeout_len  = flsc_pkg::CommsTimeoutReset;
      policy       = 1'b0;
      cmd_seen     = 1'b0;
      last_btn     = 1'b1;
      stable_btn   = 1'b1;
      pulse_on     = 1'b0;
      since_cmd    = '0;
      since_btn    = '0;
      pulse_age    = '0;
      n_fail       = 0;
      n_checked    = 0;
    endfunction

    function logic [TimerBits-1:0] bump(logic [TimerBits-1:0] count);
      return (&count) ? count : count + 1'b1;
    endfunction

    function void set_config(flsc_pkg::cfg_idx_e idx, logic [flsc_pkg::CfgDataW-1:0] val);
      case (idx)
        flsc_pkg::CfgOpenPulse:    pulse_len = val;
        flsc_pkg::CfgDebounce:     debounce_len = val[7:0];
        flsc_pkg::CfgCommsTimeout: timeout_len = val;
        default: ;
      endcase
    endfunction

    task report(string msg);
      if (n_fail < MaxPrinted) $display("mismatch at result %0d: %s", n_checked, msg);
      n_fail++;
    endtask

    // one millisecond tick of the lock controller
    function void note_request(flsc_pkg::in_item_t req);
      flsc_pkg::out_item_t res;
      logic                lost;
      logic                press;
      since_cmd = bump(since_cmd);
      since_btn = bump(since_btn);
      if (pulse_on) pulse_age = bump(pulse_age);
      if (req.command_valid) begin
        policy    = req.command_unlock;
        cmd_seen  = 1'b1;
        since_cmd = '0;
      end
      lost = !cmd_seen || (&since_cmd) || (since_cmd > timeout_len);
      if (pulse_on) begin
        if (pulse_age >= pulse_len || (&pulse_age)) pulse_on = 1'b0;
      end else if (!lost) begin
        press = 1'b0;
        if (req.button_level != last_btn) begin
          since_btn = '0;
          last_btn  = req.button_level;
        end
        if (since_btn > debounce_len && req.button_level != stable_btn) begin
          stable_btn = req.button_level;
          press      = !stable_btn;
        end
        if (press && policy && !req.door_sensor_level) begin
          pulse_on  = 1'b1;
          pulse_age = '0;
        end
      end
      res.open_drive        = pulse_on;
      res.comms_lost        = lost;
      res.policy_unlocked   = policy;
      res.physically_locked = !req.door_sensor_level;
      expected_q.push_back(res);
    endfunction

    task check_result(flsc_pkg::out_item_t got);
      flsc_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        report("result with no request pending");
      end else begin
        want = expected_q.pop_front();
        if (got.open_drive !== want.open_drive)
          report($sformatf("open_drive got %b want %b", got.open_drive, want.open_drive));
        if (got.comms_lost !== want.comms_lost)
          report($sformatf("comms_lost got %b want %b", got.comms_lost, want.comms_lost));
        if (got.policy_unlocked !== want.policy_unlocked)
          report($sformatf("policy_unlocked got %b want %b", got.policy_unlocked,
                           want.policy_unlocked));
        if (got.physically_locked !== want.physically_locked)
          report($sformatf("physically_locked got %b want %b", got.physically_locked,
                           want.physically_locked));
      end
      n_checked++;
    endtask
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  flsc_pkg::in_item_t            in_data_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  flsc_pkg::out_item_t           out_data_o;
  logic                          cfg_we_i = 1'b0;
  logic [flsc_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [flsc_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  bit                  quiet = 1'b0;
  int unsigned         n_cycles = 0;
  logic                btn_now = 1'b1;
  int unsigned         btn_left = 0;
  int unsigned         cmd_left = 0;
  lock_scoreboard      sb;

  fail_secure_lock_controller u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  initial begin : stall_gen
    bit          stalled;
    int unsigned run_left;
    stalled  = 1'b0;
    run_left = 0;
    forever begin
      @(posedge clk_i);
      if (run_left == 0) begin
        stalled  = !stalled && !quiet;
        run_left = stalled ? gap_len() : $urandom_range(1, 12);
      end else begin
        run_left--;
      end
      out_stall_i <= stalled;
    end
  end

  // button runs mostly around the debounce length, commands mostly before the timeout
  function automatic flsc_pkg::in_item_t next_item();
    flsc_pkg::in_item_t req;
    logic [3:0]         raw;
    int unsigned        lim;
    if ($urandom_range(0, 9) == 0) begin
      raw = 4'($urandom_range(0, 15));
      req = raw;
      return req;
    end
    if (btn_left == 0) begin
      btn_now  = !btn_now;
      btn_left = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2)
                 : $urandom_range(sb.debounce_len, sb.debounce_len + 4);
    end else begin
      btn_left--;
    end
    req.button_level      = btn_now;
    req.door_sensor_level = ($urandom_range(0, 4) == 0);
    req.command_unlock    = ($urandom_range(0, 4) != 0);
    req.command_valid     = (cmd_left == 0);
    if (cmd_left == 0) begin
      lim      = (sb.timeout_len > 58) ? 60 : sb.timeout_len + 2;
      cmd_left = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2 * lim)
                 : $urandom_range(0, lim);
    end else begin
      cmd_left--;
    end
    return req;
  endfunction

  task automatic send_tick(flsc_pkg::in_item_t req);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
  endtask

  task automatic pause_in(int unsigned n);
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic run_phase(int unsigned n_items);
    repeat (n_items) begin
      send_tick(next_item());
      pause_in(gap_len());
    end
  endtask

  task automatic settle();
    pause_in(1);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(flsc_pkg::cfg_idx_e idx, logic [flsc_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_config(idx, val);
  endtask

  initial begin : main
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_phase(40);
    settle();

    cfg_write(flsc_pkg::CfgOpenPulse, 16'd3);
    cfg_write(flsc_pkg::CfgDebounce, 16'd1);
    cfg_write(flsc_pkg::CfgCommsTimeout, 16'd6);
    for (int i = 0; i < 25; i++) begin
      send_tick(flsc_pkg::in_item_t'(DirectedTicks[i]));
      pause_in(gap_len());
    end

    for (int p = 0; p < 7; p++) begin
      settle();
      quiet = ($urandom_range(0, 3) == 0);
      if (p == 0) begin
        cfg_write(flsc_pkg::CfgOpenPulse, '0);
        cfg_write(flsc_pkg::CfgDebounce, '0);
        cfg_write(flsc_pkg::CfgCommsTimeout, '0);
      end else if (p == 1) begin
        cfg_write(flsc_pkg::CfgOpenPulse, 16'd1);
        cfg_write(flsc_pkg::CfgDebounce, 16'd255);
        cfg_write(flsc_pkg::CfgCommsTimeout, 16'd65534);
      end else begin
        cfg_write(flsc_pkg::CfgOpenPulse, flsc_pkg::CfgDataW'($urandom_range(1, 12)));
        cfg_write(flsc_pkg::CfgDebounce, flsc_pkg::CfgDataW'($urandom_range(0, 6)));
        cfg_write(flsc_pkg::CfgCommsTimeout, flsc_pkg::CfgDataW'($urandom_range(0, 40)));
      end
      run_phase((p == 1) ? 250 : 80);
    end

    // longest pulse length starting from a fresh command
    settle();
    quiet = 1'b1;
    cfg_write(flsc_pkg::CfgDebounce, '0);
    cfg_write(flsc_pkg::CfgCommsTimeout, 16'd65534);
    repeat (20) send_tick(flsc_pkg::in_item_t'(4'b1011));
    settle();
    cfg_write(flsc_pkg::CfgOpenPulse, 16'hffff);
    send_tick(flsc_pkg::in_item_t'(4'b1011));
    send_tick(flsc_pkg::in_item_t'(4'b1000));
    send_tick(flsc_pkg::in_item_t'(4'b0000));
    send_tick(flsc_pkg::in_item_t'(4'b0000));
    settle();
    quiet = 1'b0;

    repeat (10) @(posedge clk_i);
    if (sb.expected_q.size() != 0) sb.report("requests left without a result");
    if (sb.n_fail == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/flsc_pkg.sv
design/flsc_cfg_regs.sv
design/flsc_core.sv
design/fail_secure_lock_controller.sv
verif/testbench.sv
